// ----- src/cubic_spline_evaluator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_EVALUATOR_CORE_DEFINES_SVH
`define CUBIC_SPLINE_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - shared package
// Sizes, request and status codes, the register index and the Horner step request/response types.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int MAX_KNOTS  = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_DEPTH = 4 * MAX_KNOTS;

  localparam int DATA_W  = 32;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 8;
  localparam int KC_W    = 7;
  localparam int KA_W    = $clog2(MAX_KNOTS);
  localparam int CA_W    = $clog2(COEF_DEPTH);
  localparam int CNT_W   = $clog2(MAX_KNOTS + 1);

  // h = x - knot is exact in 33 bits; it is split at the binary point
  localparam int H_W    = DATA_W + 1;
  localparam int HLO_W  = FRAC_BITS;
  localparam int HHI_W  = H_W - FRAC_BITS;
  localparam int OP_W   = (HLO_W + 1 > HHI_W) ? HLO_W + 1 : HHI_W;
  localparam int PROD_W = DATA_W + OP_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_KNOT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL = 2'd2;

  localparam logic [PADDR_W-3:0] REG_KNOT_COUNT = 1'b0;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic                     go;
    logic signed [DATA_W-1:0] acc;
    logic signed [H_W-1:0]    h;
    logic signed [DATA_W-1:0] coef;
  } hrn_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] acc;
  } hrn_rsp_t;

endpackage

// ----- src/cse_in_if.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - request channel
// Valid/ready channel carrying mode, index and value.
// ----------------------------------------------------------------------------
interface cse_in_if;
  import cse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [INDEX_W-1:0]       index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, index, value, input ready);
  modport sink (input valid, mode, index, value, output ready);

endinterface

// ----- src/cse_out_if.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - result channel
// Valid/ready channel carrying the spline value and status.
// ----------------------------------------------------------------------------
interface cse_out_if;
  import cse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic                     status;

  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);

endinterface

// ----- src/cse_ram.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - generic RAM
// Single port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- src/cse_horner.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - Horner step unit
// acc' = sat32(coef + round(acc * h)), one multiplier shared by the low and high halves of h.
// ----------------------------------------------------------------------------
module cse_horner (
  input  logic              clk,
  input  logic              rst,
  input  cse_pkg::hrn_req_t req,
  output cse_pkg::hrn_rsp_t rsp
);
  import cse_pkg::*;

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_LO   = 2'd1;
  localparam logic [1:0] H_HI   = 2'd2;
  localparam logic [1:0] H_SUM  = 2'd3;

  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

  logic [1:0]               state;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] coef;
  logic signed [H_W-1:0]    h;
  logic signed [OP_W-1:0]   op;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] lo_rnd;
  logic signed [SUM_W-1:0]  lo_term;
  logic signed [SUM_W-1:0]  sum;
  logic [DATA_W-1:0]        sat;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (req.go) begin
            state <= H_LO;
          end
        end
        H_LO:    state <= H_HI;
        H_HI:    state <= H_SUM;
        H_SUM:   state <= H_IDLE;
        default: state <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && req.go) begin
      acc  <= req.acc;
      h    <= req.h;
      coef <= req.coef;
    end
    if (state == H_LO) begin
      prod_lo <= prod;
    end
    if (state == H_HI) begin
      prod_hi <= prod;
    end
  end

  // h = h_hi * 2^F + h_lo, h_lo unsigned
  always_comb begin
    if (state == H_LO) begin
      op = OP_W'($signed({1'b0, h[HLO_W-1:0]}));
    end else begin
      op = OP_W'($signed(h[H_W-1:HLO_W]));
    end
    prod = acc * op;
  end

  // acc*h_hi*2^F is already aligned, so only the low product needs rounding
  always_comb begin
    lo_rnd   = prod_lo + RND;
    lo_term  = SUM_W'(lo_rnd >>> FRAC_BITS);
    sum      = SUM_W'(prod_hi) + lo_term + SUM_W'(coef);
    in_range = (&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]);
    if (in_range) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
    rsp.done = (state == H_SUM);
    rsp.acc  = sat;
  end

endmodule

// ----- src/cubic_spline_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// Cubic spline evaluator - top level
// Knot and coefficient tables in RAM, binary search, Horner evaluation.
// ----------------------------------------------------------------------------
//  channel   dir  signals                              request moves
//  in_ch     in   valid ready mode index value         load knot/coef, evaluate
//  out_ch    out  valid ready result status            one per evaluate
//  apb       in   psel penable pwrite paddr pwdata     knot_count register
//
//  A load is written straight from idle. An evaluate reads the first and last
//  knots (only the first when x lies below it), then searches inside with
//  s <= ceil(log2(n-1)) search reads, one knot RAM read per search step, then
//  runs three Horner steps on the shared multiplier.
//  rst is synchronous; the tables are not cleared.
//  The result register lets a new request in while the last result stalls.
// ----------------------------------------------------------------------------
`include "cubic_spline_evaluator_core_defines.svh"

module cubic_spline_evaluator_core (
  input  logic                         clk,
  input  logic                         rst,
  cse_in_if.sink                       in_ch,
  cse_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cse_pkg::PADDR_W-1:0]  paddr,
  input  logic [cse_pkg::PDATA_W-1:0]  pwdata,
  output logic [cse_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import cse_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK_LO = 4'd1;
  localparam logic [3:0] S_CHK_HI = 4'd2;
  localparam logic [3:0] S_SRCH   = 4'd3;
  localparam logic [3:0] S_FETCH  = 4'd4;
  localparam logic [3:0] S_DIFF   = 4'd5;
  localparam logic [3:0] S_LD_D   = 4'd6;
  localparam logic [3:0] S_STEP   = 4'd7;
  localparam logic [3:0] S_WAIT   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic [1:0] PW_A = 2'd0;
  localparam logic [1:0] PW_C = 2'd2;
  localparam logic [1:0] PW_D = 2'd3;

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic [KC_W-1:0]          knot_count;
  logic [CNT_W-1:0]         n;
  logic [KA_W-1:0]          n_m1;
  logic [KA_W-1:0]          n_m2;
  logic [KA_W-1:0]          mid0;
  logic                     too_few;
  logic                     accept;
  logic                     knot_idx_ok;
  logic                     coef_idx_ok;
  logic                     apb_wr;
  logic [PADDR_W-3:0]       reg_idx;

  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] klo;
  logic signed [DATA_W-1:0] acc;
  logic signed [H_W-1:0]    h;
  logic                     st;
  logic [KA_W-1:0]          lo;
  logic [KA_W-1:0]          hi;
  logic [KA_W-1:0]          mid;
  logic [KA_W-1:0]          seg;
  logic [1:0]               pw;

  logic                     x_lt;
  logic                     x_gt;
  logic [KA_W-1:0]          lo_n;
  logic [KA_W-1:0]          hi_n;
  logic [KA_W:0]            mid_sum;
  logic [KA_W-1:0]          mid_n;
  logic                     span_gt1;

  logic                     knot_en;
  logic                     knot_we;
  logic [KA_W-1:0]          knot_addr;
  logic signed [DATA_W-1:0] knot_rdata;
  logic                     coef_en;
  logic                     coef_we;
  logic [CA_W-1:0]          coef_addr;
  logic signed [DATA_W-1:0] coef_rdata;
  logic                     hreq_go;

  hrn_req_t                 hreq;
  hrn_rsp_t                 hrsp;

  logic                     out_valid;
  logic                     out_load;
  logic signed [DATA_W-1:0] out_result;
  logic                     out_status;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign apb_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= '0;
    end else if (apb_wr && reg_idx == REG_KNOT_COUNT) begin
      knot_count <= pwdata[KC_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_KNOT_COUNT) begin
      prdata = PDATA_W'(knot_count);
    end else begin
      prdata = '0;
    end
  end

  // --------------------------------------------------------------------------
  // search helpers
  // --------------------------------------------------------------------------
  always_comb begin
    if (32'(knot_count) > MAX_KNOTS) begin
      n = CNT_W'(MAX_KNOTS);
    end else begin
      n = CNT_W'(knot_count);
    end
  end

  assign too_few     = n < CNT_W'(2);
  assign n_m1        = KA_W'(n - CNT_W'(1));
  assign n_m2        = KA_W'(n - CNT_W'(2));
  assign mid0        = n_m1 >> 1;
  assign accept      = in_ch.valid && in_ch.ready;
  assign knot_idx_ok = 32'(in_ch.index) < MAX_KNOTS;
  assign coef_idx_ok = 32'(in_ch.index) < COEF_DEPTH;

  assign x_lt     = x < knot_rdata;
  assign x_gt     = x > knot_rdata;
  assign lo_n     = x_gt ? mid : lo;
  assign hi_n     = x_gt ? hi : mid;
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n    = mid_sum[KA_W:1];
  assign span_gt1 = (hi_n - lo_n) > KA_W'(1);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    knot_en    = 1'b0;
    knot_we    = 1'b0;
    knot_addr  = '0;
    coef_en    = 1'b0;
    coef_we    = 1'b0;
    coef_addr  = '0;
    hreq_go    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_KNOT: begin
              if (knot_idx_ok) begin
                knot_en   = 1'b1;
                knot_we   = 1'b1;
                knot_addr = KA_W'(in_ch.index);
              end
            end
            MODE_COEF: begin
              if (coef_idx_ok) begin
                coef_en   = 1'b1;
                coef_we   = 1'b1;
                coef_addr = CA_W'(in_ch.index);
              end
            end
            MODE_EVAL: begin
              if (too_few) begin
                state_next = S_OUT;
              end else begin
                knot_en    = 1'b1;
                state_next = S_CHK_LO;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CHK_LO: begin
        if (x_lt) begin
          state_next = S_DIFF;
        end else begin
          knot_en    = 1'b1;
          knot_addr  = n_m1;
          state_next = S_CHK_HI;
        end
      end
      S_CHK_HI: begin
        if (x_gt) begin
          knot_en    = 1'b1;
          knot_addr  = n_m2;
          state_next = S_FETCH;
        end else if (n_m1 > KA_W'(1)) begin
          knot_en    = 1'b1;
          knot_addr  = mid0;
          state_next = S_SRCH;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_SRCH: begin
        if (span_gt1) begin
          knot_en   = 1'b1;
          knot_addr = mid_n;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_FETCH: begin
        state_next = S_DIFF;
      end
      S_DIFF: begin
        coef_en    = 1'b1;
        coef_addr  = {seg, PW_D};
        state_next = S_LD_D;
      end
      S_LD_D: begin
        coef_en    = 1'b1;
        coef_addr  = {seg, PW_C};
        state_next = S_STEP;
      end
      S_STEP: begin
        hreq_go = 1'b1;
        // prefetch the next lower coefficient while the step runs
        if (pw != PW_A) begin
          coef_en   = 1'b1;
          coef_addr = {seg, pw - 2'd1};
        end
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (hrsp.done) begin
          state_next = (pw == PW_A) ? S_OUT : S_STEP;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x   <= in_ch.value;
        acc <= '0;
        st  <= too_few ? STATUS_NOT_READY : STATUS_OK;
      end
      S_CHK_LO: begin
        klo <= knot_rdata;
        seg <= '0;
      end
      S_CHK_HI: begin
        seg <= x_gt ? n_m2 : '0;
        lo  <= '0;
        hi  <= n_m1;
        mid <= mid0;
      end
      S_SRCH: begin
        lo  <= lo_n;
        hi  <= hi_n;
        mid <= mid_n;
        seg <= lo_n;
        if (x_gt) begin
          klo <= knot_rdata;
        end
      end
      S_FETCH: begin
        klo <= knot_rdata;
      end
      S_DIFF: begin
        h <= {x[DATA_W-1], x} - {klo[DATA_W-1], klo};
      end
      S_LD_D: begin
        acc <= coef_rdata;
        pw  <= PW_C;
      end
      S_WAIT: begin
        if (hrsp.done) begin
          acc <= hrsp.acc;
          pw  <= pw - 2'd1;
        end
      end
      default: begin
        pw <= pw;
      end
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // tables and arithmetic
  // --------------------------------------------------------------------------
  cse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk   (clk),
    .en    (knot_en),
    .we    (knot_we),
    .addr  (knot_addr),
    .wdata (in_ch.value),
    .rdata (knot_rdata)
  );

  cse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .en    (coef_en),
    .we    (coef_we),
    .addr  (coef_addr),
    .wdata (in_ch.value),
    .rdata (coef_rdata)
  );

  assign hreq.go   = hreq_go;
  assign hreq.acc  = acc;
  assign hreq.h    = h;
  assign hreq.coef = coef_rdata;

  cse_horner u_horner (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= acc;
      out_status <= st;
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.result = out_result;
  assign out_ch.status = out_status;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CSE_ASSERT_IMPL(a_not_ready_zero, clk, rst, out_ch.valid && out_ch.status == STATUS_NOT_READY, out_ch.result == '0, "not-ready result is nonzero")
  `CSE_ASSERT_IMPL(a_knot_read_in_range, clk, rst, knot_en && !knot_we, 32'(knot_addr) < 32'(n), "knot read beyond loaded count")
  `CSE_ASSERT_IMPL(a_step_done_in_wait, clk, rst, hrsp.done, state == S_WAIT, "Horner step finished outside wait state")
  `CSE_ASSERT_NEXT(a_few_knots_to_out, clk, rst, accept && in_ch.mode == MODE_EVAL && too_few, state == S_OUT, "not-ready evaluate did not go to output")

endmodule
